// ----- rtl/oale_pkg.sv -----
// shared types and constants for the ordered array list engine
package oale_pkg;

    localparam int DEFAULT_CAPACITY = 256;
    localparam int WORD_W = 32;
    localparam int POS_W = 9;
    localparam int COUNT_W = 9;

    typedef enum logic [2:0] {
        OP_APPEND     = 3'd0,
        OP_INSERT     = 3'd1,
        OP_POP        = 3'd2,
        OP_REMOVE_VAL = 3'd3,
        OP_REMOVE_AT  = 3'd4,
        OP_GET        = 3'd5,
        OP_SET        = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BOUNDS   = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        op_t                       req_type;
        logic [POS_W-1:0]          position;
        logic signed [WORD_W-1:0]  word_in;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic signed [WORD_W-1:0]  word_out;
        logic [COUNT_W-1:0]        entry_count;
    } rsp_t;

endpackage

// ----- rtl/oale_mem.sv -----
// entry store: one write port, one read port with registered read data
module oale_mem #(
    parameter int DEPTH = oale_pkg::DEFAULT_CAPACITY,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [AW-1:0]                     waddr,
    input  logic signed [oale_pkg::WORD_W-1:0] wdata,
    input  logic                              re,
    input  logic [AW-1:0]                     raddr,
    output logic signed [oale_pkg::WORD_W-1:0] rdata
);
    import oale_pkg::*;

    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ordered_array_list_engine.sv -----
// top level of the ordered array list engine: request sequencer around the entry store
//
// The block holds up to CAPACITY signed 32-bit words in one synchronous memory
// plus an entry count, and handles one request at a time; a new request is
// taken once the previous one has moved its result into the output register,
// so a request can enter while the last result still waits to be taken. Every
// entry moved costs one memory read and one write, and every entry examined
// one read, pipelined at one entry per cycle through the single read and
// single write port. Steps from acceptance to result ready: append writes and
// clear resets the count on acceptance; pop, get and set read the entry once,
// set then writing the new word; insert shifts entries from the end down to
// the position up by one, then writes the new word (at once at the end);
// remove at shifts the entries after the position down by one; remove by
// value reads from index 0 to the first match, then shifts the rest down
// (not found after the last entry). There is no clearing pass after reset.
module ordered_array_list_engine #(
    parameter int CAPACITY = oale_pkg::DEFAULT_CAPACITY
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  oale_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output oale_pkg::rsp_t  rsp
);
    import oale_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_RD     = 8'b00000010,
        S_UP     = 8'b00000100,
        S_PUT    = 8'b00001000,
        S_SEARCH = 8'b00010000,
        S_TAKE   = 8'b00100000,
        S_DOWN   = 8'b01000000,
        S_DONE   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    status_t status_reg, status_next;
    logic signed [WORD_W-1:0] result_reg, result_next;
    op_t op_reg;
    logic [AW-1:0] pos_reg;
    logic signed [WORD_W-1:0] word_reg;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg;

    logic mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic signed [WORD_W-1:0] mem_wdata, mem_rdata;

    logic accept;
    logic [PW-1:0] pos_ext, count_ext;
    logic [AW-1:0] pos_addr, count_addr, last_idx;
    logic [CW-1:0] count_m1;
    logic full, empty, at_last, rsp_load;

    oale_mem #(
        .DEPTH(CAPACITY),
        .AW   (AW)
    ) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign accept = req_valid && req_ready;

    assign pos_ext = PW'(req.position);
    assign count_ext = PW'(count_reg);
    assign pos_addr = pos_ext[AW-1:0];
    assign count_addr = count_reg[AW-1:0];
    assign count_m1 = count_reg - 1'b1;
    assign last_idx = count_m1[AW-1:0];
    assign full = (count_reg == CAP_COUNT);
    assign empty = (count_reg == '0);
    assign at_last = (ptr_reg == last_idx);
    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next = ptr_reg;
        status_next = status_reg;
        result_next = result_reg;
        mem_we = 1'b0;
        mem_waddr = count_addr;
        mem_wdata = req.word_in;
        mem_re = 1'b0;
        mem_raddr = last_idx;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    result_next = '0;
                    state_next = S_DONE;
                    case (req.req_type)
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (pos_ext > count_ext)
                            begin
                                status_next = ST_BOUNDS;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (pos_ext == count_ext)
                            begin
                                mem_we = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                mem_re = 1'b1;
                                ptr_next = last_idx;
                                state_next = S_UP;
                            end
                        end
                        OP_POP:
                        begin
                            if (empty)
                            begin
                                status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                mem_re = 1'b1;
                                count_next = count_m1;
                                state_next = S_RD;
                            end
                        end
                        OP_REMOVE_VAL:
                        begin
                            if (empty)
                            begin
                                status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                mem_re = 1'b1;
                                mem_raddr = '0;
                                ptr_next = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        OP_REMOVE_AT:
                        begin
                            if (pos_ext >= count_ext)
                            begin
                                status_next = ST_BOUNDS;
                            end
                            else
                            begin
                                mem_re = 1'b1;
                                mem_raddr = pos_addr;
                                ptr_next = pos_addr;
                                state_next = S_TAKE;
                            end
                        end
                        OP_GET, OP_SET:
                        begin
                            if (pos_ext >= count_ext)
                            begin
                                status_next = ST_BOUNDS;
                            end
                            else
                            begin
                                mem_re = 1'b1;
                                mem_raddr = pos_addr;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                result_next = mem_rdata;
                if (op_reg == OP_SET)
                begin
                    mem_we = 1'b1;
                    mem_waddr = pos_reg;
                    mem_wdata = word_reg;
                end
                state_next = S_DONE;
            end
            S_UP:
            begin
                mem_we = 1'b1;
                mem_waddr = ptr_reg + 1'b1;
                mem_wdata = mem_rdata;
                if (ptr_reg == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_raddr = ptr_reg - 1'b1;
                    ptr_next = ptr_reg - 1'b1;
                end
            end
            S_PUT:
            begin
                mem_we = 1'b1;
                mem_waddr = pos_reg;
                mem_wdata = word_reg;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_SEARCH, S_TAKE:
            begin
                if ((state_reg == S_TAKE) || (mem_rdata == word_reg))
                begin
                    result_next = mem_rdata;
                    if (at_last)
                    begin
                        count_next = count_m1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mem_re = 1'b1;
                        mem_raddr = ptr_reg + 1'b1;
                        ptr_next = ptr_reg + 1'b1;
                        state_next = S_DOWN;
                    end
                end
                else if (at_last)
                begin
                    status_next = ST_NOTFOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_raddr = ptr_reg + 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_DOWN:
            begin
                mem_we = 1'b1;
                mem_waddr = ptr_reg - 1'b1;
                mem_wdata = mem_rdata;
                if (at_last)
                begin
                    count_next = count_m1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_raddr = ptr_reg + 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        status_reg <= status_next;
        result_reg <= result_next;
        if (accept)
        begin
            op_reg <= req.req_type;
            pos_reg <= pos_addr;
            word_reg <= req.word_in;
        end
        if (rsp_load)
        begin
            rsp_reg.status <= status_reg;
            rsp_reg.word_out <= result_reg;
            rsp_reg.entry_count <= count_ext[COUNT_W-1:0];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule
